FILE: sv/cpg_pkg.sv
// Shared constants, types and reset palette of the cyclic palette gradient.
package cpg_pkg;

   localparam int VALUE_BITS = 32;
   localparam int LEVEL_BITS = 8;
   localparam int CHANNELS = 3;
   localparam int ENTRY_BITS = 24;
   localparam int BAND_WIDTH_BITS = 10;
   localparam int LENGTH_BITS = 4;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 2 * ENTRY_BITS;

   localparam int DEFAULT_PALETTE_DEPTH = 8;
   localparam int DEFAULT_VALUE_FRACTION_BITS = 8;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_BAND_WIDTH = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PALETTE_LENGTH = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ENTRIES_0_1 = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ENTRIES_6_7 = 3'd5;

   localparam logic [BAND_WIDTH_BITS-1:0] RESET_BAND_WIDTH = 10'd50;
   localparam logic [LENGTH_BITS-1:0] RESET_PALETTE_LENGTH = 4'd8;

   localparam int RESET_ROWS = 4;
   localparam logic [ENTRY_BITS-1:0] RESET_PALETTE [2*RESET_ROWS] = '{
      24'h000000, 24'h0000FF, 24'h0080FF, 24'h00FF80,
      24'h808000, 24'hFF8000, 24'hFFFF80, 24'hFFFFFF
   };

   typedef struct packed {
      logic valid;
      logic nonzero;
   } band_ctl_type;

   typedef struct packed {
      logic                valid;
      logic [CHANNELS-1:0] down;
   } blend_ctl_type;

   function automatic logic [CSR_DATA_BITS-1:0] reset_row(input int row);
      logic [CSR_DATA_BITS-1:0] value;
      value = '0;
      if (row >= 0 && row < RESET_ROWS) begin
         value = {RESET_PALETTE[2*row+1], RESET_PALETTE[2*row]};
      end
      return value;
   endfunction

endpackage

FILE: sv/cpg_band_div.sv
// Band divider: escape value over band width, one quotient bit per stage.
module cpg_band_div #(
   parameter int PALETTE_DEPTH = cpg_pkg::DEFAULT_PALETTE_DEPTH,
   parameter int VALUE_FRACTION_BITS = cpg_pkg::DEFAULT_VALUE_FRACTION_BITS
) (
   input  logic                                                  clock,
   input  logic                                                  reset,
   input  logic                                                  in_valid,
   input  logic [cpg_pkg::VALUE_BITS-1:0]                        in_value,
   input  logic [cpg_pkg::BAND_WIDTH_BITS-1:0]                   width,
   input  logic [$clog2(PALETTE_DEPTH)-1:0]                      cycle_length,
   output cpg_pkg::band_ctl_type                                 out_ctl,
   output logic [cpg_pkg::BAND_WIDTH_BITS+VALUE_FRACTION_BITS-1:0] out_num,
   output logic [$clog2(PALETTE_DEPTH)-1:0]                      out_band_mod
);
   import cpg_pkg::*;

   localparam int IW = $clog2(PALETTE_DEPTH);
   localparam int BW = BAND_WIDTH_BITS;
   localparam int NW = BAND_WIDTH_BITS + VALUE_FRACTION_BITS;
   localparam int STEPS = VALUE_BITS - VALUE_FRACTION_BITS;
   localparam logic [VALUE_BITS-1:0] LOW_MASK =
      (VALUE_BITS'(1) << VALUE_FRACTION_BITS) - VALUE_BITS'(1);

   logic [STEPS:0]          valid_ff, valid_in;
   logic [STEPS:0]          nz_ff, nz_in;
   logic [VALUE_BITS-1:0]   value_ff [STEPS+1];
   logic [VALUE_BITS-1:0]   value_in [STEPS+1];
   logic [BW-1:0]           rem_ff [STEPS+1];
   logic [BW-1:0]           rem_in [STEPS+1];
   logic [IW-1:0]           mod_ff [STEPS+1];
   logic [IW-1:0]           mod_in [STEPS+1];

   always_comb begin
      logic [BW:0] trial;
      logic [IW:0] fold;
      logic        take;
      trial = '0;
      fold = '0;
      take = 1'b0;
      valid_in[0] = in_valid;
      nz_in[0] = 1'b0;
      value_in[0] = in_value;
      rem_in[0] = '0;
      mod_in[0] = '0;
      for (int i = 0; i < STEPS; i++) begin
         trial = {rem_ff[i], value_ff[i][VALUE_BITS-1-i]};
         take = trial >= {1'b0, width};
         if (take) begin
            rem_in[i+1] = BW'(trial - {1'b0, width});
         end else begin
            rem_in[i+1] = trial[BW-1:0];
         end
         // running band number modulo the cycle length
         fold = {mod_ff[i], take};
         if (fold >= {1'b0, cycle_length}) begin
            fold = fold - {1'b0, cycle_length};
         end
         mod_in[i+1] = fold[IW-1:0];
         nz_in[i+1] = nz_ff[i] | take;
         valid_in[i+1] = valid_ff[i];
         value_in[i+1] = value_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      nz_ff <= nz_in;
      value_ff <= value_in;
      rem_ff <= rem_in;
      mod_ff <= mod_in;
   end

   assign out_ctl.valid = valid_ff[STEPS];
   assign out_ctl.nonzero = nz_ff[STEPS];
   assign out_num = (NW'(rem_ff[STEPS]) << VALUE_FRACTION_BITS)
                  | NW'(value_ff[STEPS] & LOW_MASK);
   assign out_band_mod = mod_ff[STEPS];

endmodule

FILE: sv/cpg_blend.sv
// Blend pipeline: level difference times fraction, divided over eight stages.
module cpg_blend #(
   parameter int VALUE_FRACTION_BITS = cpg_pkg::DEFAULT_VALUE_FRACTION_BITS
) (
   input  logic                                                  clock,
   input  logic                                                  reset,
   input  cpg_pkg::blend_ctl_type                                in_ctl,
   input  logic [cpg_pkg::LEVEL_BITS-1:0]                        in_base [cpg_pkg::CHANNELS],
   input  logic [cpg_pkg::LEVEL_BITS-1:0]                        in_diff [cpg_pkg::CHANNELS],
   input  logic [cpg_pkg::BAND_WIDTH_BITS+VALUE_FRACTION_BITS-1:0] in_num,
   input  logic [cpg_pkg::BAND_WIDTH_BITS-1:0]                   width,
   output logic                                                  out_valid,
   output logic [cpg_pkg::LEVEL_BITS-1:0]                        out_level [cpg_pkg::CHANNELS]
);
   import cpg_pkg::*;

   localparam int NW = BAND_WIDTH_BITS + VALUE_FRACTION_BITS;
   localparam int PW = LEVEL_BITS + NW;
   localparam int STEPS = LEVEL_BITS;

   blend_ctl_type         ctl_ff [STEPS+1];
   blend_ctl_type         ctl_in [STEPS+1];
   logic [PW-1:0]         rest_ff [STEPS+1][CHANNELS];
   logic [PW-1:0]         rest_in [STEPS+1][CHANNELS];
   logic [LEVEL_BITS-1:0] quot_ff [STEPS+1][CHANNELS];
   logic [LEVEL_BITS-1:0] quot_in [STEPS+1][CHANNELS];
   logic [LEVEL_BITS-1:0] base_ff [STEPS+1][CHANNELS];
   logic [LEVEL_BITS-1:0] base_in [STEPS+1][CHANNELS];
   logic [LEVEL_BITS-1:0] level_ff [CHANNELS];
   logic [LEVEL_BITS-1:0] level_in [CHANNELS];
   logic                  out_valid_ff;

   always_comb begin
      logic [PW-1:0] step_div;
      logic          round_up;
      step_div = '0;
      round_up = 1'b0;
      ctl_in[0] = in_ctl;
      for (int c = 0; c < CHANNELS; c++) begin
         rest_in[0][c] = PW'(in_diff[c]) * PW'(in_num);
         quot_in[0][c] = '0;
         base_in[0][c] = in_base[c];
      end
      for (int s = 1; s <= STEPS; s++) begin
         ctl_in[s] = ctl_ff[s-1];
         step_div = PW'(width) << (VALUE_FRACTION_BITS + STEPS - s);
         for (int c = 0; c < CHANNELS; c++) begin
            base_in[s][c] = base_ff[s-1][c];
            quot_in[s][c] = quot_ff[s-1][c];
            if (rest_ff[s-1][c] >= step_div) begin
               rest_in[s][c] = rest_ff[s-1][c] - step_div;
               quot_in[s][c][STEPS-s] = 1'b1;
            end else begin
               rest_in[s][c] = rest_ff[s-1][c];
            end
         end
      end
      // falling channels round the step up so the level is floored
      for (int c = 0; c < CHANNELS; c++) begin
         round_up = ctl_ff[STEPS].down[c] && (rest_ff[STEPS][c] != '0);
         if (ctl_ff[STEPS].down[c]) begin
            level_in[c] = base_ff[STEPS][c] - quot_ff[STEPS][c]
                        - {{(LEVEL_BITS-1){1'b0}}, round_up};
         end else begin
            level_in[c] = base_ff[STEPS][c] + quot_ff[STEPS][c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= STEPS; s++) begin
            ctl_ff[s] <= '0;
         end
         out_valid_ff <= 1'b0;
      end else begin
         ctl_ff <= ctl_in;
         out_valid_ff <= ctl_ff[STEPS].valid;
      end
   end

   always_ff @(posedge clock) begin
      rest_ff <= rest_in;
      quot_ff <= quot_in;
      base_ff <= base_in;
      level_ff <= level_in;
   end

   assign out_valid = out_valid_ff;
   assign out_level = level_ff;

endmodule

FILE: sv/cyclic_palette_gradient.sv
// Top level of the cyclic palette gradient colouriser.
//
//   channel   ports                          beat marked by
//   request   req_escape_value               start && !busy
//   response  rsp_red/green/blue_level       rsp_strobe, one cycle
//   csr       csr_index, csr_data            csr_valid && csr_ready
//
// One escape value accepted per cycle outside reset; each passes through the
// one-bit-per-stage band divider (32 - VALUE_FRACTION_BITS stages) and the
// eight-stage fraction divider. Synchronous reset empties the pipeline and
// restores the registers; palette rows read as reset colours until written.
// busy is high only during reset; csr_ready is always high. Nothing stalls.
module cyclic_palette_gradient #(
   parameter int PALETTE_DEPTH = cpg_pkg::DEFAULT_PALETTE_DEPTH,
   parameter int VALUE_FRACTION_BITS = cpg_pkg::DEFAULT_VALUE_FRACTION_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [cpg_pkg::VALUE_BITS-1:0]      req_escape_value,
   output logic                                rsp_strobe,
   output logic [cpg_pkg::LEVEL_BITS-1:0]      rsp_red_level,
   output logic [cpg_pkg::LEVEL_BITS-1:0]      rsp_green_level,
   output logic [cpg_pkg::LEVEL_BITS-1:0]      rsp_blue_level,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cpg_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [cpg_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import cpg_pkg::*;

   localparam int IW = $clog2(PALETTE_DEPTH);
   localparam int BW = BAND_WIDTH_BITS;
   localparam int NW = BAND_WIDTH_BITS + VALUE_FRACTION_BITS;
   localparam int ROWS = (PALETTE_DEPTH + 1) / 2;
   localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int LATENCY = VALUE_BITS - VALUE_FRACTION_BITS + 13;
   localparam logic [LENGTH_BITS:0] DEPTH_LENGTH = (LENGTH_BITS+1)'(PALETTE_DEPTH);
   localparam logic [LENGTH_BITS:0] MIN_LENGTH = (LENGTH_BITS+1)'(2);

   logic [BW-1:0]             band_width_ff;
   logic [LENGTH_BITS-1:0]    palette_length_ff;
   logic [ROWS-1:0]           row_valid_ff;
   logic [CSR_DATA_BITS-1:0]  palette_mem [ROWS];

   logic                      csr_write;
   logic                      row_write;
   logic [CSR_INDEX_BITS-1:0] csr_row;
   logic [RW-1:0]             csr_row_addr;
   logic [LENGTH_BITS:0]      length_eff;
   logic [IW-1:0]             cycle_m;
   logic [BW-1:0]             width_eff;

   band_ctl_type              band_ctl;
   logic [NW-1:0]             band_num;
   logic [IW-1:0]             band_mod;

   logic [IW-1:0]             base_idx;
   logic [IW-1:0]             top_idx;
   logic [RW-1:0]             row_a;
   logic [RW-1:0]             row_b;

   logic                      read_valid_ff;
   logic [NW-1:0]             read_num_ff;
   logic                      read_half_a_ff;
   logic                      read_half_b_ff;
   logic                      read_ok_a_ff;
   logic                      read_ok_b_ff;
   logic [CSR_DATA_BITS-1:0]  read_a_ff;
   logic [CSR_DATA_BITS-1:0]  read_b_ff;
   logic [CSR_DATA_BITS-1:0]  read_reset_a_ff;
   logic [CSR_DATA_BITS-1:0]  read_reset_b_ff;

   logic [CSR_DATA_BITS-1:0]  row_data_a;
   logic [CSR_DATA_BITS-1:0]  row_data_b;
   logic [ENTRY_BITS-1:0]     entry_a;
   logic [ENTRY_BITS-1:0]     entry_b;
   blend_ctl_type             entry_ctl_ff, entry_ctl_in;
   logic [LEVEL_BITS-1:0]     entry_base_ff [CHANNELS];
   logic [LEVEL_BITS-1:0]     entry_base_in [CHANNELS];
   logic [LEVEL_BITS-1:0]     entry_diff_ff [CHANNELS];
   logic [LEVEL_BITS-1:0]     entry_diff_in [CHANNELS];
   logic [NW-1:0]             entry_num_ff;

   logic [LEVEL_BITS-1:0]     level [CHANNELS];

   assign busy = reset;
   assign csr_ready = 1'b1;

   // ---- registers
   assign csr_write = csr_valid && csr_ready;
   assign csr_row = csr_index - CSR_ENTRIES_0_1;
   assign csr_row_addr = RW'(csr_row);
   assign row_write = csr_write && (csr_index >= CSR_ENTRIES_0_1)
                    && (csr_index <= CSR_ENTRIES_6_7) && (int'(csr_row) < ROWS);

   always_ff @(posedge clock) begin
      if (reset) begin
         band_width_ff <= RESET_BAND_WIDTH;
         palette_length_ff <= RESET_PALETTE_LENGTH;
         row_valid_ff <= '0;
      end else begin
         if (csr_write && csr_index == CSR_BAND_WIDTH) begin
            band_width_ff <= csr_data[BW-1:0];
         end
         if (csr_write && csr_index == CSR_PALETTE_LENGTH) begin
            palette_length_ff <= csr_data[LENGTH_BITS-1:0];
         end
         if (row_write) begin
            row_valid_ff[csr_row_addr] <= 1'b1;
         end
      end
   end

   always_comb begin
      length_eff = {1'b0, palette_length_ff};
      if (length_eff < MIN_LENGTH) begin
         length_eff = MIN_LENGTH;
      end else if (length_eff > DEPTH_LENGTH) begin
         length_eff = DEPTH_LENGTH;
      end
   end

   assign cycle_m = IW'(length_eff - (LENGTH_BITS+1)'(1));
   assign width_eff = (band_width_ff == '0) ? BW'(1) : band_width_ff;

   // ---- band number and remainder
   cpg_band_div #(
      .PALETTE_DEPTH       (PALETTE_DEPTH),
      .VALUE_FRACTION_BITS (VALUE_FRACTION_BITS)
   ) u_band_div (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (start && !busy),
      .in_value     (req_escape_value),
      .width        (width_eff),
      .cycle_length (cycle_m),
      .out_ctl      (band_ctl),
      .out_num      (band_num),
      .out_band_mod (band_mod)
   );

   // ---- palette lookup
   always_comb begin
      if (!band_ctl.nonzero) begin
         base_idx = '0;
         top_idx = IW'(1);
      end else begin
         base_idx = (band_mod == '0) ? cycle_m : band_mod;
         top_idx = (base_idx == cycle_m) ? IW'(1) : IW'(base_idx + IW'(1));
      end
   end

   assign row_a = RW'(base_idx >> 1);
   assign row_b = RW'(top_idx >> 1);

   always_ff @(posedge clock) begin
      if (row_write) begin
         palette_mem[csr_row_addr] <= csr_data;
      end
      read_a_ff <= palette_mem[row_a];
      read_b_ff <= palette_mem[row_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         read_valid_ff <= 1'b0;
         entry_ctl_ff <= '0;
      end else begin
         read_valid_ff <= band_ctl.valid;
         entry_ctl_ff <= entry_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      read_num_ff <= band_num;
      read_half_a_ff <= base_idx[0];
      read_half_b_ff <= top_idx[0];
      read_ok_a_ff <= row_valid_ff[row_a];
      read_ok_b_ff <= row_valid_ff[row_b];
      read_reset_a_ff <= reset_row(int'(row_a));
      read_reset_b_ff <= reset_row(int'(row_b));
   end

   // ---- endpoint levels
   assign row_data_a = read_ok_a_ff ? read_a_ff : read_reset_a_ff;
   assign row_data_b = read_ok_b_ff ? read_b_ff : read_reset_b_ff;
   assign entry_a = read_half_a_ff ? row_data_a[CSR_DATA_BITS-1:ENTRY_BITS]
                                   : row_data_a[ENTRY_BITS-1:0];
   assign entry_b = read_half_b_ff ? row_data_b[CSR_DATA_BITS-1:ENTRY_BITS]
                                   : row_data_b[ENTRY_BITS-1:0];

   always_comb begin
      logic [LEVEL_BITS-1:0] lo;
      logic [LEVEL_BITS-1:0] hi;
      lo = '0;
      hi = '0;
      entry_ctl_in.valid = read_valid_ff;
      entry_ctl_in.down = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         lo = entry_a[ENTRY_BITS-1-LEVEL_BITS*c -: LEVEL_BITS];
         hi = entry_b[ENTRY_BITS-1-LEVEL_BITS*c -: LEVEL_BITS];
         entry_ctl_in.down[c] = hi < lo;
         entry_base_in[c] = lo;
         entry_diff_in[c] = (hi < lo) ? (lo - hi) : (hi - lo);
      end
   end

   always_ff @(posedge clock) begin
      entry_base_ff <= entry_base_in;
      entry_diff_ff <= entry_diff_in;
      entry_num_ff <= read_num_ff;
   end

   // ---- blend
   cpg_blend #(
      .VALUE_FRACTION_BITS (VALUE_FRACTION_BITS)
   ) u_blend (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (entry_ctl_ff),
      .in_base   (entry_base_ff),
      .in_diff   (entry_diff_ff),
      .in_num    (entry_num_ff),
      .width     (width_eff),
      .out_valid (rsp_strobe),
      .out_level (level)
   );

   assign rsp_red_level = level[0];
   assign rsp_green_level = level[1];
   assign rsp_blue_level = level[2];

   // ---- assertions
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LATENCY))
      else $error("response beat without a request beat at fixed latency");

   assert property (@(posedge clock) disable iff (reset)
      band_ctl.valid |-> (base_idx <= cycle_m && top_idx <= cycle_m && top_idx != '0))
      else $error("palette index outside the active cycle");

   for (genvar r = 0; r < ROWS; r++) begin : g_row_check
      assert property (@(posedge clock) disable iff (reset)
         $rose(row_valid_ff[r]) |-> $past(row_write && int'(csr_row) == r))
         else $error("palette row marked written without a csr beat");
   end

endmodule

FILE: tb/tb_cyclic_palette_gradient.sv
// Self-checking testbench for cyclic_palette_gradient: directed table, then random phases.
`timescale 1ns / 1ps

module tb_cyclic_palette_gradient;
   import cpg_pkg::*;

   localparam int PALETTE_DEPTH = DEFAULT_PALETTE_DEPTH;
   localparam int FRACTION_BITS = DEFAULT_VALUE_FRACTION_BITS;
   localparam int PIPE_LATENCY = 45 - FRACTION_BITS;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS = 150;
   localparam int DIRECTED_ROWS = 29;
   localparam longint WATCHDOG_NS = 2000000;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_ENTRIES_2_3 = CSR_ENTRIES_0_1 + 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ENTRIES_4_5 = CSR_ENTRIES_0_1 + 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_A = CSR_ENTRIES_6_7 + 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_B = CSR_ENTRIES_6_7 + 3'd2;

   typedef struct packed {
      logic [LEVEL_BITS-1:0] red;
      logic [LEVEL_BITS-1:0] green;
      logic [LEVEL_BITS-1:0] blue;
   } colour_type;

   typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type              kind;
      logic [VALUE_BITS-1:0]     value;
      logic                      typed;
      colour_type                want;
      logic [CSR_INDEX_BITS-1:0] index;
      logic [CSR_DATA_BITS-1:0]  data;
   } row_type;

   // band width 50 gives a band of 12800; 1023 gives 261888
   localparam row_type DIRECTED [DIRECTED_ROWS] = '{
      '{ROW_PIXEL, 32'd0,          1'b1, 24'h000000, '0, '0},
      '{ROW_PIXEL, 32'd12799,      1'b0, 24'h000000, '0, '0},
      '{ROW_PIXEL, 32'd12800,      1'b1, 24'h0000FF, '0, '0},
      '{ROW_PIXEL, 32'd25600,      1'b1, 24'h0080FF, '0, '0},
      '{ROW_PIXEL, 32'd89600,      1'b1, 24'hFFFFFF, '0, '0},
      '{ROW_PIXEL, 32'd102400,     1'b1, 24'h0000FF, '0, '0},
      '{ROW_PIXEL, 32'hFFFFFFFF,   1'b0, 24'h000000, '0, '0},
      '{ROW_WRITE, '0, 1'b0, '0, CSR_BAND_WIDTH, 48'hFFFF_FFFF_FC00},
      '{ROW_PIXEL, 32'd255,        1'b0, 24'h000000, '0, '0},
      '{ROW_PIXEL, 32'd256,        1'b1, 24'h0000FF, '0, '0},
      '{ROW_WRITE, '0, 1'b0, '0, CSR_PALETTE_LENGTH, 48'h0000_0000_0001},
      '{ROW_PIXEL, 32'h12345678,   1'b1, 24'h0000FF, '0, '0},
      '{ROW_WRITE, '0, 1'b0, '0, CSR_PALETTE_LENGTH, 48'h0000_0000_000F},
      '{ROW_PIXEL, 32'hFFFFFFFF,   1'b0, 24'h000000, '0, '0},
      '{ROW_WRITE, '0, 1'b0, '0, CSR_BAND_WIDTH, 48'h0000_0000_03FF},
      '{ROW_WRITE, '0, 1'b0, '0, CSR_ENTRIES_0_1, 48'h000000_FFFFFF},
      '{ROW_PIXEL, 32'd0,          1'b1, 24'hFFFFFF, '0, '0},
      '{ROW_PIXEL, 32'd261887,     1'b0, 24'h000000, '0, '0},
      '{ROW_WRITE, '0, 1'b0, '0, CSR_SPARE_A, 48'hFFFF_FFFF_FFFF},
      '{ROW_WRITE, '0, 1'b0, '0, CSR_SPARE_B, 48'hFFFF_FFFF_FFFF},
      '{ROW_PIXEL, 32'd261888,     1'b1, 24'h000000, '0, '0},
      '{ROW_WRITE, '0, 1'b0, '0, CSR_ENTRIES_6_7, 48'hFFFFFF_000000},
      '{ROW_PIXEL, 32'd1833216,    1'b1, 24'hFFFFFF, '0, '0},
      '{ROW_PIXEL, 32'd1571328,    1'b1, 24'h000000, '0, '0},
      '{ROW_PIXEL, 32'd1571327,    1'b0, 24'h000000, '0, '0},
      '{ROW_WRITE, '0, 1'b0, '0, CSR_PALETTE_LENGTH, 48'hFFFF_FFFF_FFF0},
      '{ROW_PIXEL, 32'd1310440,    1'b1, 24'h000000, '0, '0},
      '{ROW_PIXEL, 32'h80000001,   1'b0, 24'h000000, '0, '0},
      '{ROW_PIXEL, 32'd261887,     1'b0, 24'h000000, '0, '0}
   };

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic [VALUE_BITS-1:0]     req_escape_value = '0;
   logic                      csr_valid = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;
   logic                      busy;
   logic                      rsp_strobe;
   logic [LEVEL_BITS-1:0]     rsp_red_level;
   logic [LEVEL_BITS-1:0]     rsp_green_level;
   logic [LEVEL_BITS-1:0]     rsp_blue_level;
   logic                      csr_ready;

   logic [BAND_WIDTH_BITS-1:0] band_width_q = RESET_BAND_WIDTH;
   logic [LENGTH_BITS-1:0]     palette_length_q = RESET_PALETTE_LENGTH;
   logic [ENTRY_BITS-1:0]      palette_q [PALETTE_DEPTH];

   colour_type colour_q [$];
   colour_type due_colour;
   int         failures = 0;

   cyclic_palette_gradient #(
      .PALETTE_DEPTH(PALETTE_DEPTH),
      .VALUE_FRACTION_BITS(FRACTION_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_escape_value(req_escape_value),
      .rsp_strobe(rsp_strobe),
      .rsp_red_level(rsp_red_level),
      .rsp_green_level(rsp_green_level),
      .rsp_blue_level(rsp_blue_level),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [LEVEL_BITS-1:0] mix_level(input logic [LEVEL_BITS-1:0] a,
                                                       input logic [LEVEL_BITS-1:0] b,
                                                       input longint unsigned num,
                                                       input longint unsigned den);
      longint unsigned span;
      if (b >= a) begin
         span = 64'(b - a);
         return a + LEVEL_BITS'((span * num) / den);
      end
      span = 64'(a - b);
      return a - LEVEL_BITS'((span * num + den - 64'd1) / den);
   endfunction

   function automatic colour_type gradient_colour(input logic [VALUE_BITS-1:0] value);
      longint unsigned band, span, rest, num, lim;
      int              base, top;
      logic [ENTRY_BITS-1:0] lo, hi;
      colour_type      c;
      band = (band_width_q == '0) ? 64'd1 : 64'(band_width_q);
      lim = 64'(palette_length_q);
      if (lim < 64'd2) lim = 64'd2;
      if (lim > 64'(PALETTE_DEPTH)) lim = 64'(PALETTE_DEPTH);
      span = band << FRACTION_BITS;
      if (64'(value) < span) begin
         lo = palette_q[0];
         hi = palette_q[1];
         num = 64'(value);
      end else begin
         rest = 64'(value) - span;
         base = int'((rest / span) % (lim - 64'd1)) + 1;
         top = base + 1;
         if (top >= int'(lim)) top = 1;
         lo = palette_q[base];
         hi = palette_q[top];
         num = rest % span;
      end
      c.red = mix_level(lo[23:16], hi[23:16], num, span);
      c.green = mix_level(lo[15:8], hi[15:8], num, span);
      c.blue = mix_level(lo[7:0], hi[7:0], num, span);
      return c;
   endfunction

   task automatic flag_fault(input string note);
      failures++;
      $display("%0t ns: mismatch: %s", $realtime, note);
   endtask

   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic settle;
      start <= 1'b0;
      while (colour_q.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 4) @(posedge clock);
   endtask

   task automatic send_pixel(input logic [VALUE_BITS-1:0] value, input logic typed,
                             input colour_type want);
      start <= 1'b1;
      req_escape_value <= value;
      do @(posedge clock); while (busy);
      colour_q.push_back(typed ? want : gradient_colour(value));
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] data);
      int first;
      settle();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (index)
         CSR_BAND_WIDTH: band_width_q = data[BAND_WIDTH_BITS-1:0];
         CSR_PALETTE_LENGTH: palette_length_q = data[LENGTH_BITS-1:0];
         CSR_ENTRIES_0_1, CSR_ENTRIES_2_3, CSR_ENTRIES_4_5, CSR_ENTRIES_6_7: begin
            first = 2 * int'(index - CSR_ENTRIES_0_1);
            if (first < PALETTE_DEPTH) palette_q[first] = data[ENTRY_BITS-1:0];
            if (first + 1 < PALETTE_DEPTH) palette_q[first+1] = data[2*ENTRY_BITS-1:ENTRY_BITS];
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (colour_q.size() == 0) begin
            flag_fault("response beat with nothing outstanding");
         end else begin
            due_colour = colour_q.pop_front();
            if (rsp_red_level !== due_colour.red)
               flag_fault($sformatf("red %0h, want %0h", rsp_red_level, due_colour.red));
            if (rsp_green_level !== due_colour.green)
               flag_fault($sformatf("green %0h, want %0h", rsp_green_level, due_colour.green));
            if (rsp_blue_level !== due_colour.blue)
               flag_fault($sformatf("blue %0h, want %0h", rsp_blue_level, due_colour.blue));
         end
      end
   end

   initial begin
      #(WATCHDOG_NS);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      logic [BAND_WIDTH_BITS-1:0] bw;
      logic [LENGTH_BITS-1:0]     len;
      logic [CSR_DATA_BITS-1:0]   word;
      longint unsigned            span, eff_len, k, pick;
      int                         burst_left, mode;
      for (int i = 0; i < PALETTE_DEPTH; i++)
         palette_q[i] = (i < 2 * RESET_ROWS) ? RESET_PALETTE[i] : '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         if (DIRECTED[i].kind == ROW_WRITE) begin
            write_csr(DIRECTED[i].index, DIRECTED[i].data);
         end else begin
            pause_sender($urandom_range(0, 2));
            send_pixel(DIRECTED[i].value, DIRECTED[i].typed, DIRECTED[i].want);
         end
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin bw = 10'd1;    len = 4'd2;  end
            1: begin bw = 10'd1023; len = 4'd8;  end
            2: begin bw = 10'd0;    len = 4'd15; end
            3: begin bw = BAND_WIDTH_BITS'($urandom_range(1, 1023)); len = 4'd0; end
            default: begin
               bw = BAND_WIDTH_BITS'($urandom_range(0, 1023));
               len = LENGTH_BITS'($urandom_range(0, 15));
            end
         endcase
         word = CSR_DATA_BITS'({$urandom, $urandom});
         word[BAND_WIDTH_BITS-1:0] = bw;
         write_csr(CSR_BAND_WIDTH, word);
         word = CSR_DATA_BITS'({$urandom, $urandom});
         word[LENGTH_BITS-1:0] = len;
         write_csr(CSR_PALETTE_LENGTH, word);
         for (int idx = CSR_ENTRIES_0_1; idx <= CSR_ENTRIES_6_7; idx++)
            write_csr(CSR_INDEX_BITS'(idx), CSR_DATA_BITS'({$urandom, $urandom}));
         if ($urandom_range(0, 1))
            write_csr($urandom_range(0, 1) ? CSR_SPARE_A : CSR_SPARE_B,
                      CSR_DATA_BITS'({$urandom, $urandom}));

         span = ((bw == '0) ? 64'd1 : 64'(bw)) << FRACTION_BITS;
         eff_len = (len < 4'd2) ? 64'd2
                 : ((int'(len) > PALETTE_DEPTH) ? 64'(PALETTE_DEPTH) : 64'(len));
         burst_left = 0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (burst_left == 0) begin
               pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
               burst_left = $urandom_range(1, 40);
            end
            burst_left--;
            mode = $urandom_range(0, 9);
            if (mode < 5) begin
               pick = 64'($urandom_range(0, 32'(span * (eff_len + 64'd1))));
            end else if (mode < 7) begin
               k = 64'($urandom_range(1, 32'(64'd3 * eff_len)));
               pick = k * span + 64'($urandom_range(0, 2)) - 64'd1;
            end else begin
               pick = 64'($urandom);
            end
            send_pixel(VALUE_BITS'(pick), 1'b0, '0);
         end
      end

      settle();
      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: cyclic_palette_gradient.f
sv/cpg_pkg.sv
sv/cpg_band_div.sv
sv/cpg_blend.sv
sv/cyclic_palette_gradient.sv
tb/tb_cyclic_palette_gradient.sv
